// ===== hw/rtl/midi_harmony_note_differ_defines.svh =====
// Assertion macros for the chord-to-MIDI note differ.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef MIDI_HARMONY_NOTE_DIFFER_DEFINES_SVH
`define MIDI_HARMONY_NOTE_DIFFER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MHND_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MHND_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mhnd_pkg.sv =====
// Shared types and constants for the chord-to-MIDI note differ.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps

package mhnd_pkg;

  // Note map geometry
  localparam int NOTE_COUNT  = 128;
  localparam int NOTE_W      = 7;
  localparam int GRP_W       = 16;
  localparam int GRP_IDX_W   = 3;
  localparam int BIT_IDX_W   = 4;

  // Field widths
  localparam int NAME_W      = 8;
  localparam int ROOT_W      = 4;
  localparam int PCM_W       = 12;
  localparam int VOICE_W     = 8;
  localparam int OFFSET_W    = 12;
  localparam int VEL_W       = 7;
  localparam int MODE_W      = 3;
  localparam int CHAN_W      = 5;
  localparam int INC_W       = 4;

  // Configuration port
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN = 1'b1;

  // Harmony mode codes
  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FULL   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_THIRD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIFTH  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OCTAVE = 3'd4;

  // Musical constants
  localparam int                CHORD_BASE = 60;
  localparam logic [ROOT_W-1:0] ROOT_WRAP  = 4'd12;
  localparam logic [NOTE_W-1:0] NOTE_MAX   = 7'd127;
  localparam logic [INC_W-1:0]  INC_MINOR  = 4'd3;
  localparam logic [INC_W-1:0]  INC_MAJOR  = 4'd4;
  localparam logic [INC_W-1:0]  INC_FIFTH  = 4'd7;
  localparam logic [INC_W-1:0]  INC_OCTAVE = 4'd12;
  localparam logic [VEL_W-1:0]  VEL_ON     = 7'd100;
  localparam logic [VEL_W-1:0]  VEL_OFF    = 7'd0;
  localparam logic [CHAN_W-1:0] CHAN_RESET = 5'd1;
  localparam logic [VOICE_W-1:0] VOICE_NONE = 8'hFF;

  // One chord report
  typedef struct packed {
    logic                       func;
    logic                       chord_valid;
    logic [NAME_W-1:0]          chord_name_code;
    logic [ROOT_W-1:0]          chord_root;
    logic                       chord_minor_like;
    logic [PCM_W-1:0]           pitch_class_mask;
    logic signed [VOICE_W-1:0]  voice_note;
    logic [OFFSET_W-1:0]        event_offset;
  } item_t;

  // One note event
  typedef struct packed {
    logic                 is_note_on;
    logic [NOTE_W-1:0]    note_number;
    logic [VEL_W-1:0]     velocity;
    logic [CHAN_W-1:0]    channel_out;
    logic [OFFSET_W-1:0]  offset_out;
    logic                 last_event;
  } result_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIFF,
    ST_SCAN
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic                 capture;
    logic                 update;
    logic                 diff;
    logic                 emit;
    logic                 sel_on;
    logic [GRP_IDX_W-1:0] grp;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic work_nz;
    logic cur_nz;
    logic grp_nz;
    logic last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/mhnd_if.sv =====
// Valid/ready channel interfaces: chord reports in, note events out, config writes.
// Depends on mhnd_pkg for field widths.
`timescale 1ns / 1ps

interface mhnd_in_if;
  logic                               valid;
  logic                               ready;
  logic                               func;
  logic                               chord_valid;
  logic [mhnd_pkg::NAME_W-1:0]        chord_name_code;
  logic [mhnd_pkg::ROOT_W-1:0]        chord_root;
  logic                               chord_minor_like;
  logic [mhnd_pkg::PCM_W-1:0]         pitch_class_mask;
  logic signed [mhnd_pkg::VOICE_W-1:0] voice_note;
  logic [mhnd_pkg::OFFSET_W-1:0]      event_offset;

  modport source (
    output valid, func, chord_valid, chord_name_code, chord_root, chord_minor_like,
           pitch_class_mask, voice_note, event_offset,
    input  ready
  );
  modport sink (
    input  valid, func, chord_valid, chord_name_code, chord_root, chord_minor_like,
           pitch_class_mask, voice_note, event_offset,
    output ready
  );
endinterface

interface mhnd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          is_note_on;
  logic [mhnd_pkg::NOTE_W-1:0]   note_number;
  logic [mhnd_pkg::VEL_W-1:0]    velocity;
  logic [mhnd_pkg::CHAN_W-1:0]   channel_out;
  logic [mhnd_pkg::OFFSET_W-1:0] offset_out;
  logic                          last_event;

  modport source (
    output valid, is_note_on, note_number, velocity, channel_out, offset_out, last_event,
    input  ready
  );
  modport sink (
    input  valid, is_note_on, note_number, velocity, channel_out, offset_out, last_event,
    output ready
  );
endinterface

interface mhnd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mhnd_pkg::CFG_IDX_W-1:0]  addr;
  logic [mhnd_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

// ===== hw/rtl/mhnd_ctrl.sv =====
// Sequencer for the note differ: update, difference, then group-wise event scan.
// Depends on mhnd_pkg for state, command and status types.
`timescale 1ns / 1ps

module mhnd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mhnd_pkg::sts_t sts_i,
  output mhnd_pkg::cmd_t cmd_o
);

  mhnd_pkg::ctrl_state_e                state_q, state_d;
  logic [mhnd_pkg::GRP_IDX_W-1:0]       grp_q, grp_d;
  logic                                 phase_q, phase_d;

  // State, group pointer and off/on phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhnd_pkg::ST_IDLE;
      grp_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
      phase_q <= phase_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    grp_d         = grp_q;
    phase_d       = phase_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.sel_on  = phase_q;
    cmd_o.grp     = grp_q;
    unique case (state_q)
      mhnd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = mhnd_pkg::ST_UPDATE;
        end
      end
      mhnd_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = mhnd_pkg::ST_DIFF;
      end
      mhnd_pkg::ST_DIFF: begin
        cmd_o.diff = 1'b1;
        grp_d      = '0;
        phase_d    = 1'b0;
        state_d    = mhnd_pkg::ST_SCAN;
      end
      mhnd_pkg::ST_SCAN: begin
        priority if (!sts_i.work_nz) begin
          state_d = mhnd_pkg::ST_IDLE;
        end else if (!sts_i.cur_nz) begin
          // offs exhausted, start the note-on pass
          phase_d = 1'b1;
          grp_d   = '0;
        end else if (!sts_i.grp_nz) begin
          grp_d = grp_q + 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) begin
            state_d = mhnd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = mhnd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/mhnd_dpath.sv =====
// Datapath of the note differ: note maps, wanted-set builder, diff vectors,
// group priority encoder and output register. Depends on mhnd_pkg.
`timescale 1ns / 1ps

module mhnd_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mhnd_pkg::cmd_t                  cmd_i,
  output mhnd_pkg::sts_t                  sts_o,
  input  mhnd_pkg::item_t                 item_i,
  input  logic                            cfg_valid_i,
  input  logic [mhnd_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [mhnd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output mhnd_pkg::result_t               out_data_o
);

  localparam int NC = mhnd_pkg::NOTE_COUNT;
  localparam int NW = mhnd_pkg::NOTE_W;

  // Captured report
  mhnd_pkg::item_t                  item_q;

  // Block state
  logic [NC-1:0]                    active_q, pending_q;
  logic [NC-1:0]                    offs_q, ons_q;
  logic                             rebuild_q;
  logic [mhnd_pkg::NAME_W-1:0]      prev_name_q;
  logic                             prev_valid_q;
  logic [mhnd_pkg::VOICE_W-1:0]     prev_voice_q;
  logic [mhnd_pkg::MODE_W-1:0]      mode_q;
  logic [mhnd_pkg::CHAN_W-1:0]      chan_q;
  logic                             out_valid_q;
  mhnd_pkg::result_t                out_data_q;

  // Wanted-set builder
  logic [mhnd_pkg::ROOT_W-1:0]      root_mod;
  logic [NW-1:0]                    src;
  logic                             src_ok;
  logic [mhnd_pkg::INC_W-1:0]       inc;
  logic [NW:0]                      harm_sum;
  logic [NW-1:0]                    harm;
  logic [NC-1:0]                    build;
  logic                             changed;

  always_comb begin
    root_mod = (item_q.chord_root >= mhnd_pkg::ROOT_WRAP) ?
               item_q.chord_root - mhnd_pkg::ROOT_WRAP : item_q.chord_root;
    if (!item_q.voice_note[mhnd_pkg::VOICE_W-1]) begin
      src    = item_q.voice_note[NW-1:0];
      src_ok = 1'b1;
    end else begin
      src    = NW'(mhnd_pkg::CHORD_BASE) + NW'(root_mod);
      src_ok = item_q.chord_valid;
    end
    unique case (mode_q)
      mhnd_pkg::MODE_THIRD:  inc = item_q.chord_minor_like ? mhnd_pkg::INC_MINOR
                                                           : mhnd_pkg::INC_MAJOR;
      mhnd_pkg::MODE_FIFTH:  inc = mhnd_pkg::INC_FIFTH;
      mhnd_pkg::MODE_OCTAVE: inc = mhnd_pkg::INC_OCTAVE;
      default:               inc = '0;
    endcase
    harm_sum = (NW+1)'(src) + (NW+1)'(inc);
    harm     = harm_sum[NW] ? mhnd_pkg::NOTE_MAX : harm_sum[NW-1:0];
    build    = '0;
    if (mode_q == mhnd_pkg::MODE_FULL) begin
      if (item_q.chord_valid) begin
        build[mhnd_pkg::CHORD_BASE +: mhnd_pkg::PCM_W] = item_q.pitch_class_mask;
      end
    end else if (src_ok && (harm != src)) begin
      build[harm] = 1'b1;
    end
    changed = (item_q.chord_name_code != prev_name_q) ||
              (item_q.chord_valid != prev_valid_q) ||
              (item_q.voice_note != prev_voice_q);
  end

  // Scan of one 16-note group of the current diff vector
  logic [NC-1:0]                    work;
  logic [mhnd_pkg::GRP_W-1:0]       grp_bits;
  logic [mhnd_pkg::BIT_IDX_W-1:0]   bit_idx;
  logic [NW-1:0]                    note;
  logic                             rem_nz;

  always_comb begin
    work     = cmd_i.sel_on ? ons_q : offs_q;
    grp_bits = work[{cmd_i.grp, {mhnd_pkg::BIT_IDX_W{1'b0}}} +: mhnd_pkg::GRP_W];
    bit_idx  = '0;
    for (int i = mhnd_pkg::GRP_W - 1; i >= 0; i--) begin
      if (grp_bits[i]) begin
        bit_idx = mhnd_pkg::BIT_IDX_W'(i);
      end
    end
    note   = {cmd_i.grp, bit_idx};
    rem_nz = |(work & ~(NC'(1) << note));
  end

  assign sts_o.work_nz  = (|offs_q) || (|ons_q);
  assign sts_o.cur_nz   = |work;
  assign sts_o.grp_nz   = |grp_bits;
  assign sts_o.last     = !rem_nz && (cmd_i.sel_on || !(|ons_q));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Report capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
  end

  // Maps, change tracking and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= '0;
      pending_q    <= '0;
      offs_q       <= '0;
      ons_q        <= '0;
      rebuild_q    <= 1'b0;
      prev_name_q  <= '0;
      prev_valid_q <= 1'b0;
      prev_voice_q <= mhnd_pkg::VOICE_NONE;
      mode_q       <= mhnd_pkg::MODE_OFF;
      chan_q       <= mhnd_pkg::CHAN_RESET;
    end else begin
      // recompute the wanted set
      if (cmd_i.update && !item_q.func) begin
        if (mode_q == mhnd_pkg::MODE_OFF) begin
          if (|active_q) begin
            pending_q <= '0;
            rebuild_q <= 1'b1;
          end
        end else if (changed || rebuild_q) begin
          prev_name_q  <= item_q.chord_name_code;
          prev_valid_q <= item_q.chord_valid;
          prev_voice_q <= item_q.voice_note;
          pending_q    <= build;
          rebuild_q    <= (build != active_q);
        end
      end
      // form the off and on vectors, commit the new active map
      if (cmd_i.diff) begin
        if (item_q.func) begin
          offs_q    <= active_q;
          ons_q     <= '0;
          active_q  <= '0;
          pending_q <= '0;
          rebuild_q <= 1'b0;
        end else if (rebuild_q) begin
          offs_q    <= active_q & ~pending_q;
          ons_q     <= pending_q & ~active_q;
          active_q  <= pending_q;
          rebuild_q <= 1'b0;
        end else begin
          offs_q <= '0;
          ons_q  <= '0;
        end
      end
      // retire the emitted note
      if (cmd_i.emit) begin
        if (cmd_i.sel_on) begin
          ons_q[note] <= 1'b0;
        end else begin
          offs_q[note] <= 1'b0;
        end
      end
      // register writes; a mode write marks a rebuild
      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          mhnd_pkg::CFG_MODE: begin
            mode_q    <= cfg_wdata_i[mhnd_pkg::MODE_W-1:0];
            rebuild_q <= 1'b1;
          end
          mhnd_pkg::CFG_CHAN: chan_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q.is_note_on  <= cmd_i.sel_on;
      out_data_q.note_number <= note;
      out_data_q.velocity    <= cmd_i.sel_on ? mhnd_pkg::VEL_ON : mhnd_pkg::VEL_OFF;
      out_data_q.channel_out <= chan_q;
      out_data_q.offset_out  <= item_q.event_offset;
      out_data_q.last_event  <= sts_o.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/midi_harmony_note_differ.sv =====
// Top level of the chord-to-MIDI note differ: controller, datapath, channel glue.
// Depends on mhnd_pkg, mhnd_if, mhnd_ctrl, mhnd_dpath and the assertion macros.
//
//   channel | dir | transfer moves
//   --------+-----+------------------------------------------------------------
//   in_i    | in  | one chord report (func, chord fields, voice note, offset)
//   out_o   | out | one note event (on/off, note, velocity, channel, offset, last)
//   cfg_i   | in  | one register write (index 0 harmony mode, 1 MIDI channel)
//
// One report at a time: accept, update, diff, then a scan.
// Each scan cycle emits one event, skips an empty 16-note group, or switches
// from the note-off pass to the note-on pass; a report yields at most 24 events.
// The output register stalls the scan.
// Reset is asynchronous, active low; no clearing pass. Config writes always land.
`timescale 1ns / 1ps
`include "midi_harmony_note_differ_defines.svh"

module midi_harmony_note_differ (
  input  logic       clk_i,
  input  logic       rst_ni,
  mhnd_in_if.sink    in_i,
  mhnd_out_if.source out_o,
  mhnd_cfg_if.sink   cfg_i
);

  mhnd_pkg::cmd_t    cmd;
  mhnd_pkg::sts_t    sts;
  mhnd_pkg::item_t   item;
  mhnd_pkg::result_t res;
  logic              in_ready;
  logic              out_valid;

  // Gather the report fields
  always_comb begin
    item.func             = in_i.func;
    item.chord_valid      = in_i.chord_valid;
    item.chord_name_code  = in_i.chord_name_code;
    item.chord_root       = in_i.chord_root;
    item.chord_minor_like = in_i.chord_minor_like;
    item.pitch_class_mask = in_i.pitch_class_mask;
    item.voice_note       = in_i.voice_note;
    item.event_offset     = in_i.event_offset;
  end

  mhnd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mhnd_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item),
    .cfg_valid_i (cfg_i.valid),
    .cfg_addr_i  (cfg_i.addr),
    .cfg_wdata_i (cfg_i.wdata),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_data_o  (res)
  );

  // Channel handshakes and event fields
  assign in_i.ready        = in_ready;
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid;
  assign out_o.is_note_on  = res.is_note_on;
  assign out_o.note_number = res.note_number;
  assign out_o.velocity    = res.velocity;
  assign out_o.channel_out = res.channel_out;
  assign out_o.offset_out  = res.offset_out;
  assign out_o.last_event  = res.last_event;

  // Checks
  `MHND_ASSERT_NEXT(a_one_report, in_i.valid && in_i.ready, !in_i.ready, "second report taken while busy")
  `MHND_ASSERT_NOW(a_emit_free, cmd.emit, !out_o.valid || out_o.ready, "event overwrote a waiting event")
  `MHND_ASSERT_NOW(a_emit_note, cmd.emit, sts.grp_nz && sts.work_nz, "event emitted from an empty group")

endmodule

// ===== sim/mhnd_note_event_check.sv =====
// Checker for the chord-to-MIDI note differ: watches the report, event and config channels,
// predicts the note events of each accepted report and compares them in order.
// Depends on mhnd_pkg and the channel interfaces in mhnd_if.
`timescale 1ns / 1ps

module mhnd_note_event_check
  import mhnd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mhnd_in_if          in_mon,
  mhnd_out_if         out_mon,
  mhnd_cfg_if         cfg_mon,
  output int unsigned outstanding_o,
  output int unsigned mismatches_o
);

  localparam int MAX_EVENTS = 24;

  // Predicted copy of the block state and registers
  logic [NOTE_COUNT-1:0] sounding_notes;
  logic [NOTE_COUNT-1:0] wanted_notes;
  logic                  rebuild_due;
  logic [NAME_W-1:0]     last_name;
  logic                  last_valid;
  logic [VOICE_W-1:0]    last_voice;
  logic [MODE_W-1:0]     harmony_mode;
  logic [CHAN_W-1:0]     midi_channel;

  result_t     expected_events[$];
  result_t     oldest;
  item_t       report;
  int unsigned mismatches;

  // Notes the current mode wants to sound for one report
  function automatic logic [NOTE_COUNT-1:0] chord_notes(input item_t rep);
    logic [NOTE_COUNT-1:0] notes;
    int                    src;
    int                    harm;
    notes = '0;
    if (harmony_mode == MODE_FULL) begin
      if (rep.chord_valid && rep.pitch_class_mask != '0) begin
        for (int k = 0; k < PCM_W; k++)
          if (rep.pitch_class_mask[k]) notes[CHORD_BASE + k] = 1'b1;
      end
    end else if ($signed(rep.voice_note) >= 0 || rep.chord_valid) begin
      // voice note wins over the chord root in octave 4
      if ($signed(rep.voice_note) >= 0) src = int'($signed(rep.voice_note));
      else src = CHORD_BASE + int'(rep.chord_root) % int'(ROOT_WRAP);
      harm = src;
      case (harmony_mode)
        MODE_THIRD:  harm = src + (rep.chord_minor_like ? int'(INC_MINOR) : int'(INC_MAJOR));
        MODE_FIFTH:  harm = src + int'(INC_FIFTH);
        MODE_OCTAVE: harm = src + int'(INC_OCTAVE);
        default:     harm = src;  // undefined codes add nothing
      endcase
      if (harm > int'(NOTE_MAX)) harm = int'(NOTE_MAX);
      if (harm != src) notes[harm] = 1'b1;
    end
    return notes;
  endfunction

  // Update the predicted state for one report and queue its note events
  task automatic predict_note_events(input item_t rep);
    int   ev_note[$];
    bit   ev_on[$];
    bit   changed;
    result_t ev;
    if (rep.func) begin
      for (int n = 0; n < NOTE_COUNT; n++)
        if (sounding_notes[n] && ev_note.size() < MAX_EVENTS) begin
          ev_note.push_back(n);
          ev_on.push_back(1'b0);
        end
      sounding_notes = '0;
      wanted_notes   = '0;
      rebuild_due    = 1'b0;
    end else begin
      if (harmony_mode == MODE_OFF) begin
        if (sounding_notes != '0) begin
          wanted_notes = '0;
          rebuild_due  = 1'b1;
        end
      end else begin
        changed = rep.chord_name_code != last_name || rep.chord_valid != last_valid ||
                  rep.voice_note != last_voice;
        if (changed || rebuild_due) begin
          last_name    = rep.chord_name_code;
          last_valid   = rep.chord_valid;
          last_voice   = rep.voice_note;
          wanted_notes = chord_notes(rep);
          rebuild_due  = wanted_notes != sounding_notes;
        end
      end
      if (rebuild_due) begin
        // note-offs first, then note-ons, both ascending
        for (int n = 0; n < NOTE_COUNT; n++)
          if (sounding_notes[n] && !wanted_notes[n] && ev_note.size() < MAX_EVENTS) begin
            ev_note.push_back(n);
            ev_on.push_back(1'b0);
          end
        for (int n = 0; n < NOTE_COUNT; n++)
          if (wanted_notes[n] && !sounding_notes[n] && ev_note.size() < MAX_EVENTS) begin
            ev_note.push_back(n);
            ev_on.push_back(1'b1);
          end
        sounding_notes = wanted_notes;
        rebuild_due    = 1'b0;
      end
    end
    foreach (ev_note[i]) begin
      ev.is_note_on  = ev_on[i];
      ev.note_number = NOTE_W'(ev_note[i]);
      ev.velocity    = ev_on[i] ? VEL_ON : VEL_OFF;
      ev.channel_out = midi_channel;
      ev.offset_out  = rep.event_offset;
      ev.last_event  = (i == ev_note.size() - 1);
      expected_events.push_back(ev);
    end
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", fname, want, got);
      mismatches++;
    end
  endtask

  // Config writes, then event transfers, then report transfers, all sampled at the edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sounding_notes = '0;
      wanted_notes   = '0;
      rebuild_due    = 1'b0;
      last_name      = '0;
      last_valid     = 1'b0;
      last_voice     = VOICE_NONE;
      harmony_mode   = MODE_OFF;
      midi_channel   = CHAN_RESET;
      mismatches     = 0;
      expected_events.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.addr == CFG_MODE) begin
          harmony_mode = cfg_mon.wdata[MODE_W-1:0];
          rebuild_due  = 1'b1;
        end else if (cfg_mon.addr == CFG_CHAN) begin
          midi_channel = cfg_mon.wdata[CHAN_W-1:0];
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_events.size() == 0) begin
          $error("note event transfer with nothing expected: note %0d on %0b",
                 out_mon.note_number, out_mon.is_note_on);
          mismatches++;
        end else begin
          oldest = expected_events.pop_front();
          check_field("is_note_on", oldest.is_note_on, out_mon.is_note_on);
          check_field("note_number", oldest.note_number, out_mon.note_number);
          check_field("velocity", oldest.velocity, out_mon.velocity);
          check_field("channel_out", oldest.channel_out, out_mon.channel_out);
          check_field("offset_out", oldest.offset_out, out_mon.offset_out);
          check_field("last_event", oldest.last_event, out_mon.last_event);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        report.func             = in_mon.func;
        report.chord_valid      = in_mon.chord_valid;
        report.chord_name_code  = in_mon.chord_name_code;
        report.chord_root       = in_mon.chord_root;
        report.chord_minor_like = in_mon.chord_minor_like;
        report.pitch_class_mask = in_mon.pitch_class_mask;
        report.voice_note       = in_mon.voice_note;
        report.event_offset     = in_mon.event_offset;
        predict_note_events(report);
      end
    end
    outstanding_o = expected_events.size();
    mismatches_o  = mismatches;
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the note differ testbench: clock, reset, report and config stimulus, verdict.
// Depends on mhnd_pkg, mhnd_if, the block midi_harmony_note_differ and mhnd_note_event_check.
`timescale 1ns / 1ps

module testbench;
  import mhnd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNDEF   = 3'd7;
  localparam int                SETTLE_CYCLES = 50;   // longest scan plus margin
  localparam int                BLOCKS        = 12;
  localparam int                BLOCK_ITEMS   = 8;

  logic        clk_i;
  logic        rst_ni;
  int unsigned outstanding;
  int unsigned mismatches;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [MODE_W-1:0] next_mode;

  mhnd_in_if  in_if ();
  mhnd_out_if out_if ();
  mhnd_cfg_if cfg_if ();

  midi_harmony_note_differ uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  mhnd_note_event_check event_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_mon       (cfg_if),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stalls at random
  always @(negedge clk_i) out_if.ready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic item_t chord(input logic f, input logic v, input logic [NAME_W-1:0] name,
                                  input logic [ROOT_W-1:0] root, input logic minor,
                                  input logic [PCM_W-1:0] mask, input logic [VOICE_W-1:0] voice,
                                  input logic [OFFSET_W-1:0] offs);
    item_t r;
    r.func             = f;
    r.chord_valid      = v;
    r.chord_name_code  = name;
    r.chord_root       = root;
    r.chord_minor_like = minor;
    r.pitch_class_mask = mask;
    r.voice_note       = voice;
    r.event_offset     = offs;
    return r;
  endfunction

  // Mostly real chord updates, names from a small set so repeats happen
  function automatic item_t random_chord();
    item_t r;
    r.func             = ($urandom_range(99) < 8);
    r.chord_valid      = ($urandom_range(99) < 85);
    r.chord_name_code  = ($urandom_range(3) == 0) ? NAME_W'($urandom) : NAME_W'($urandom_range(7));
    r.chord_root       = ROOT_W'($urandom);
    r.chord_minor_like = 1'($urandom);
    r.pitch_class_mask = ($urandom_range(9) == 0) ? '0 : PCM_W'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: r.voice_note = VOICE_NONE;
      9:             r.voice_note = VOICE_W'($urandom);
      default:       r.voice_note = VOICE_W'($urandom_range(127));
    endcase
    r.event_offset     = OFFSET_W'($urandom);
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_report(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.func             <= it.func;
    in_if.chord_valid      <= it.chord_valid;
    in_if.chord_name_code  <= it.chord_name_code;
    in_if.chord_root       <= it.chord_root;
    in_if.chord_minor_like <= it.chord_minor_like;
    in_if.pitch_class_mask <= it.pitch_class_mask;
    in_if.voice_note       <= it.voice_note;
    in_if.event_offset     <= it.event_offset;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  // Hold off reports until every expected event is out and the scan has ended
  task automatic settle();
    in_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_mode(input logic [MODE_W-1:0] m, input logic [CHAN_W-1:0] chan);
    settle();
    write_register(CFG_CHAN, CFG_DATA_W'(chan));
    write_register(CFG_MODE, CFG_DATA_W'(m));
  endtask

  initial begin
    in_if.valid            = 1'b0;
    in_if.func             = 1'b0;
    in_if.chord_valid      = 1'b0;
    in_if.chord_name_code  = '0;
    in_if.chord_root       = '0;
    in_if.chord_minor_like = 1'b0;
    in_if.pitch_class_mask = '0;
    in_if.voice_note       = '0;
    in_if.event_offset     = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.addr            = CFG_MODE;
    cfg_if.wdata           = '0;
    out_if.ready           = 1'b0;
    send_idle_pct          = 28;
    recv_idle_pct          = 51;
    rst_ni                 = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: off mode after reset with nothing sounding
    send_report(chord(1'b0, 1'b1, 8'd1, 4'd1, 1'b0, 12'hFFF, VOICE_NONE, 12'd0));

    // Full chord: all twelve, shrink, swap, repeat, invalid, empty mask, release
    set_mode(MODE_FULL, 5'd16);
    send_report(chord(1'b0, 1'b1, 8'd1, 4'd0, 1'b0, 12'hFFF, VOICE_NONE, 12'hFFF));
    send_report(chord(1'b0, 1'b1, 8'd2, 4'd0, 1'b0, 12'h001, VOICE_NONE, 12'h000));
    send_report(chord(1'b0, 1'b1, 8'd3, 4'd0, 1'b0, 12'h800, VOICE_NONE, 12'h5A5));
    send_report(chord(1'b0, 1'b1, 8'd3, 4'd0, 1'b0, 12'h800, VOICE_NONE, 12'h5A5));
    send_report(chord(1'b0, 1'b0, 8'd3, 4'd0, 1'b0, 12'h800, VOICE_NONE, 12'hA5A));
    send_report(chord(1'b0, 1'b1, 8'd4, 4'd0, 1'b0, 12'h000, VOICE_NONE, 12'd7));
    send_report(chord(1'b0, 1'b1, 8'd5, 4'd0, 1'b0, 12'hFFF, VOICE_NONE, 12'd8));
    send_report(chord(1'b1, 1'b1, 8'd5, 4'd0, 1'b0, 12'hFFF, VOICE_NONE, 12'd9));
    send_report(chord(1'b1, 1'b1, 8'd5, 4'd0, 1'b0, 12'hFFF, VOICE_NONE, 12'd10));

    // Third: root source, root above eleven, clamp onto the source, clamp, no source
    set_mode(MODE_THIRD, 5'd31);
    send_report(chord(1'b0, 1'b1, 8'd10, 4'd0, 1'b0, 12'h091, VOICE_NONE, 12'd11));
    send_report(chord(1'b0, 1'b1, 8'd11, 4'd15, 1'b1, 12'h091, VOICE_NONE, 12'd12));
    send_report(chord(1'b0, 1'b1, 8'd11, 4'd15, 1'b1, 12'h091, 8'd127, 12'd13));
    send_report(chord(1'b0, 1'b1, 8'd11, 4'd15, 1'b0, 12'h091, 8'd125, 12'd14));
    send_report(chord(1'b0, 1'b0, 8'd0, 4'd2, 1'b0, 12'h091, 8'h80, 12'd15));

    // Fifth with channel zero (out of range)
    set_mode(MODE_FIFTH, 5'd0);
    send_report(chord(1'b0, 1'b0, 8'd20, 4'd0, 1'b0, 12'h000, 8'd0, 12'd16));
    send_report(chord(1'b0, 1'b1, 8'd20, 4'd0, 1'b0, 12'h000, 8'd120, 12'd17));

    set_mode(MODE_OCTAVE, 5'd1);
    send_report(chord(1'b0, 1'b1, 8'd21, 4'd4, 1'b0, 12'h010, 8'd60, 12'd18));
    send_report(chord(1'b0, 1'b1, 8'd21, 4'd4, 1'b0, 12'h010, 8'd127, 12'd19));
    send_report(chord(1'b0, 1'b1, 8'd21, 4'd4, 1'b0, 12'h010, 8'd100, 12'd20));

    // Off mode drops what sounds, then stays quiet
    set_mode(MODE_OFF, 5'd1);
    send_report(chord(1'b0, 1'b1, 8'd22, 4'd0, 1'b0, 12'h001, 8'd40, 12'd21));
    send_report(chord(1'b0, 1'b1, 8'd23, 4'd0, 1'b0, 12'h001, 8'd41, 12'd22));

    // Undefined mode code never wants a note
    set_mode(MODE_UNDEF, 5'd1);
    send_report(chord(1'b0, 1'b1, 8'd9, 4'd0, 1'b0, 12'h001, 8'd50, 12'd23));
    send_report(chord(1'b0, 1'b1, 8'hFF, 4'd5, 1'b1, 12'hFFF, VOICE_NONE, 12'd24));

    // Random blocks: a fresh mode and channel each, idling profile per third of the run
    for (int blk = 0; blk < BLOCKS; blk++) begin
      case (blk / 4)
        0:       begin send_idle_pct = 28; recv_idle_pct = 51; end
        1:       begin send_idle_pct = 51; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      case ($urandom_range(9))
        8:       next_mode = MODE_OFF;
        9:       next_mode = MODE_W'(5 + $urandom_range(2));
        default: next_mode = MODE_W'(1 + $urandom_range(3));
      endcase
      case (blk % 4)
        0:       set_mode(next_mode, 5'd1);
        1:       set_mode(next_mode, 5'd16);
        2:       set_mode(next_mode, $urandom_range(1) ? 5'd31 : 5'd0);
        default: set_mode(next_mode, CHAN_W'($urandom));
      endcase
      for (int i = 0; i < BLOCK_ITEMS; i++) send_report(random_chord());
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("[midi_harmony_note_differ] OK");
    end else begin
      $display("[midi_harmony_note_differ] ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("[midi_harmony_note_differ] ERROR");
    $finish;
  end

endmodule

// ===== midi_harmony_note_differ.f =====
+incdir+hw/rtl
hw/rtl/mhnd_pkg.sv
hw/rtl/mhnd_if.sv
hw/rtl/mhnd_ctrl.sv
hw/rtl/mhnd_dpath.sv
hw/rtl/midi_harmony_note_differ.sv
sim/mhnd_note_event_check.sv
sim/testbench.sv
